// ----- rtl/i2cmws_pkg.sv -----
package i2cmws_pkg;

   // Item function codes.
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_ACK_LIMIT = 1'b0;
   localparam logic CSR_STOP_HOLD = 1'b1;

   localparam int CSR_DATA_W = 20;

   localparam logic [19:0] ACK_LIMIT_RESET = 20'd1000000;
   localparam logic [3:0]  STOP_HOLD_RESET = 4'd10;

   typedef struct packed {
      logic [1:0] func;
      logic       sda_in;
      logic [3:0] buf_index;
      logic [7:0] byte_value;
      logic [4:0] byte_count;
      logic [7:0] address_byte;
   } req_payload_type;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic busy_res;
      logic frame_done;
      logic timed_out;
   } rsp_payload_type;

   // Sequencer phases, one-hot.
   typedef enum logic [8:0] {
      PH_IDLE    = 9'b000000001,
      PH_PRE     = 9'b000000010,
      PH_ST_SDA  = 9'b000000100,
      PH_ST_SCL  = 9'b000001000,
      PH_BIT     = 9'b000010000,
      PH_ACK     = 9'b000100000,
      PH_SP_SDA  = 9'b001000000,
      PH_SP_SCL  = 9'b010000000,
      PH_SP_HOLD = 9'b100000000
   } phase_type;

   // Frame buffer write request from the sequencer.
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } buf_write_type;

endpackage

// ----- rtl/i2cmws_buf.sv -----
module i2cmws_buf
   import i2cmws_pkg::*;
#(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic          clock,
   input  buf_write_type wr,
   input  logic [4:0]    rd_pos,
   output logic [7:0]    rd_data
);

   localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   logic [7:0]       mem [BUFFER_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;

   assign wr_idx  = IDX_W'(wr.addr);
   assign rd_idx  = IDX_W'(rd_pos);
   assign rd_data = rd_data_ff;

   // A write to the entry being read this cycle is forwarded, so the
   // registered read always reflects every earlier write.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_idx] <= wr.data;
      end
      if (wr.en && (wr_idx == rd_idx)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_idx];
      end
   end

endmodule

// ----- rtl/i2cmws_seq.sv -----
module i2cmws_seq
   import i2cmws_pkg::*;
#(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  accept,
   input  req_payload_type       req,
   input  logic [7:0]            rd_data,
   output buf_write_type         wr,
   output logic [4:0]            rd_pos,
   output rsp_payload_type       rsp
);

   logic [19:0] ack_limit_ff;
   logic [3:0]  stop_hold_ff;

   phase_type   phase_ff,   phase_in;
   logic [2:0]  bit_pos_ff, bit_pos_in;
   logic [3:0]  sub_ff,     sub_in;
   logic [4:0]  byte_pos_ff, byte_pos_in;
   logic [4:0]  to_send_ff, to_send_in;
   logic [7:0]  shift_ff,   shift_in;
   logic [19:0] ack_cnt_ff, ack_cnt_in;
   logic        scl_ff,     scl_in;
   logic        sda_ff,     sda_in;
   logic        tmo_ff,     tmo_in;
   logic        done;
   logic        cur_bit;
   logic [20:0] ack_next;
   logic [8:0]  count_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_limit_ff <= ACK_LIMIT_RESET;
         stop_hold_ff <= STOP_HOLD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ACK_LIMIT: ack_limit_ff <= csr_write_data[19:0];
            CSR_STOP_HOLD: stop_hold_ff <= csr_write_data[3:0];
            default:       ack_limit_ff <= ack_limit_ff;
         endcase
      end
   end

   assign cur_bit   = shift_ff[bit_pos_ff];
   assign ack_next  = {1'b0, ack_cnt_ff} + 21'd1;
   assign count_sat = (9'(req.byte_count) > 9'(BUFFER_DEPTH)) ?
                      9'(BUFFER_DEPTH) : 9'(req.byte_count);

   always_comb begin
      phase_in    = phase_ff;
      bit_pos_in  = bit_pos_ff;
      sub_in      = sub_ff;
      byte_pos_in = byte_pos_ff;
      to_send_in  = to_send_ff;
      shift_in    = shift_ff;
      ack_cnt_in  = ack_cnt_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      tmo_in      = tmo_ff;
      done        = 1'b0;
      wr.en       = 1'b0;
      wr.addr     = {4'd0, req.buf_index};
      wr.data     = req.byte_value;

      if (accept) begin
         priority if (req.func == FUNC_TICK && phase_ff != PH_IDLE) begin
            unique case (phase_ff)
               PH_PRE: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_ST_SDA;
               end
               PH_ST_SDA: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = PH_ST_SCL;
               end
               PH_ST_SCL: begin
                  scl_in     = 1'b0;
                  sda_in     = 1'b0;
                  bit_pos_in = 3'd7;
                  sub_in     = 4'd0;
                  phase_in   = PH_BIT;
               end
               PH_BIT: begin
                  sda_in = cur_bit;
                  priority if (sub_ff == 4'd0) begin
                     scl_in = 1'b0;
                     sub_in = 4'd1;
                  end else if (sub_ff == 4'd1) begin
                     scl_in = 1'b1;
                     sub_in = 4'd2;
                  end else begin
                     scl_in = 1'b0;
                     sub_in = 4'd0;
                     if (bit_pos_ff == 3'd0) begin
                        phase_in = PH_ACK;
                     end else begin
                        bit_pos_in = bit_pos_ff - 3'd1;
                     end
                  end
               end
               PH_ACK: begin
                  sda_in = 1'b1;
                  priority if (sub_ff == 4'd0) begin
                     scl_in = 1'b0;
                     if (req.sda_in) begin
                        if (ack_next > {1'b0, ack_limit_ff}) begin
                           scl_in   = 1'b1;
                           tmo_in   = 1'b1;
                           phase_in = PH_IDLE;
                           done     = 1'b1;
                        end else begin
                           ack_cnt_in = ack_next[19:0];
                        end
                     end else begin
                        sub_in = 4'd1;
                     end
                  end else if (sub_ff == 4'd1) begin
                     scl_in = 1'b1;
                     sub_in = 4'd2;
                  end else begin
                     scl_in = 1'b0;
                     sub_in = 4'd0;
                     if (byte_pos_ff < to_send_ff) begin
                        shift_in    = rd_data;
                        byte_pos_in = byte_pos_ff + 5'd1;
                        bit_pos_in  = 3'd7;
                        phase_in    = PH_BIT;
                     end else begin
                        phase_in = PH_SP_SDA;
                     end
                  end
               end
               PH_SP_SDA: begin
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
                  phase_in = PH_SP_SCL;
               end
               PH_SP_SCL: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  sub_in   = 4'd0;
                  phase_in = PH_SP_HOLD;
               end
               PH_SP_HOLD: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
                  if ({1'b0, sub_ff} + 5'd1 >= {1'b0, stop_hold_ff}) begin
                     phase_in = PH_IDLE;
                     sub_in   = 4'd0;
                     done     = 1'b1;
                  end else begin
                     sub_in = sub_ff + 4'd1;
                  end
               end
               default: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_IDLE;
               end
            endcase
         end else if (req.func == FUNC_LOAD) begin
            wr.en = (9'(req.buf_index) < 9'(BUFFER_DEPTH));
         end else if (req.func == FUNC_START && phase_ff == PH_IDLE) begin
            shift_in    = req.address_byte;
            to_send_in  = count_sat[4:0];
            byte_pos_in = 5'd0;
            bit_pos_in  = 3'd7;
            sub_in      = 4'd0;
            ack_cnt_in  = 20'd0;
            tmo_in      = 1'b0;
            phase_in    = PH_PRE;
         end else begin
            done = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_pos_ff  <= 3'd7;
         sub_ff      <= 4'd0;
         byte_pos_ff <= 5'd0;
         to_send_ff  <= 5'd0;
         shift_ff    <= 8'd0;
         ack_cnt_ff  <= 20'd0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         tmo_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         bit_pos_ff  <= bit_pos_in;
         sub_ff      <= sub_in;
         byte_pos_ff <= byte_pos_in;
         to_send_ff  <= to_send_in;
         shift_ff    <= shift_in;
         ack_cnt_ff  <= ack_cnt_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         tmo_ff      <= tmo_in;
      end
   end

   // The buffer is read ahead at the position the next byte will come from.
   assign rd_pos = byte_pos_in;

   assign rsp.scl_level  = scl_in;
   assign rsp.sda_level  = sda_in;
   assign rsp.busy_res   = (phase_in != PH_IDLE);
   assign rsp.frame_done = done;
   assign rsp.timed_out  = tmo_in;

endmodule

// ----- rtl/i2cmws_skid.sv -----
module i2cmws_skid
   import i2cmws_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_stall,
   input  rsp_payload_type in_data,
   output logic            out_valid,
   input  logic            out_stall,
   output rsp_payload_type out_data
);

   logic            out_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type skid_data_ff;
   logic            take;
   logic            push;

   assign take      = out_valid_ff && !out_stall;
   assign push      = in_valid && !skid_valid_ff;
   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !take) begin
            skid_data_ff <= in_data;
         end else begin
            out_data_ff <= in_data;
         end
      end
   end

endmodule

// ----- rtl/i2c_master_write_sequencer.sv -----
// Result: an accepted transaction's result is registered in the output skid stage and shown on rsp_.
// Throughput: one transaction per clock while req_stall is low, set by the sequencer step and the
// registered read of the frame buffer memory.
// Reset is synchronous and active high; it returns the sequencer to idle with both lines
// released and restores the register defaults. The frame buffer is not cleared.
module i2c_master_write_sequencer
   import i2cmws_pkg::*;
#(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload
);

   // A request transaction is taken whenever the output skid stage has room.
   // The output register plus one skid entry let the sequencer keep working
   // while a finished result waits, and req_stall comes straight from a flop.
   logic            accept;
   buf_write_type   buf_wr;
   logic [4:0]      buf_rd_pos;
   logic [7:0]      buf_rd_data;
   rsp_payload_type seq_rsp;

   assign accept = req_valid && !req_stall;

   // The frame buffer is a synchronous memory. It is read every cycle at the
   // position of the next data byte, so the byte is ready by the time the
   // acknowledge of the previous byte finishes. Loads to that same entry are
   // forwarded inside the memory block.
   i2cmws_buf #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr      (buf_wr),
      .rd_pos  (buf_rd_pos),
      .rd_data (buf_rd_data)
   );

   // The sequencer advances the bus phase on each tick transaction, handles
   // buffer loads and frame starts, and holds the configuration registers.
   i2cmws_seq #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .req            (req_payload),
      .rd_data        (buf_rd_data),
      .wr             (buf_wr),
      .rd_pos         (buf_rd_pos),
      .rsp            (seq_rsp)
   );

   // Every accepted transaction yields exactly one result transaction.
   i2cmws_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (seq_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

endmodule

// ----- tb/i2cmws_checker.sv -----
`timescale 1ns / 1ps

module i2cmws_checker
   import i2cmws_pkg::*;
#(
   parameter int BUFFER_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_payload,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_payload,

   output int                    fail_count,
   output int                    expected_left
);

   // Shadow of the sequencer and its registers.
   logic [7:0]  frame_bytes [BUFFER_DEPTH];
   phase_type   seq_phase = PH_IDLE;
   logic [2:0]  bit_idx;
   logic [3:0]  tick_in_bit;
   logic [4:0]  next_byte;
   logic [4:0]  byte_total;
   logic [7:0]  tx_byte;
   logic [19:0] ack_waits;
   logic        scl_out;
   logic        sda_out;
   logic        timeout_seen;
   logic [19:0] limit_cfg;
   logic [3:0]  hold_cfg;

   rsp_payload_type line_queue [$];

   initial begin
      for (int i = 0; i < BUFFER_DEPTH; i++)
         frame_bytes[i] = 8'h00;
   end

   // Applies one transaction to the shadow and returns the lines it should produce.
   function automatic rsp_payload_type sequencer_step(req_payload_type item);
      rsp_payload_type lines;
      logic            done;
      logic [20:0]     wait_next;
      done = 1'b0;
      case (item.func)
         FUNC_TICK: begin
            if (seq_phase != PH_IDLE) begin
               case (seq_phase)
                  PH_PRE: begin
                     scl_out = 1'b1;
                     sda_out = 1'b1;
                     seq_phase = PH_ST_SDA;
                  end
                  PH_ST_SDA: begin
                     scl_out = 1'b1;
                     sda_out = 1'b0;
                     seq_phase = PH_ST_SCL;
                  end
                  PH_ST_SCL: begin
                     scl_out = 1'b0;
                     sda_out = 1'b0;
                     bit_idx = 3'd7;
                     tick_in_bit = 4'd0;
                     seq_phase = PH_BIT;
                  end
                  PH_BIT: begin
                     sda_out = tx_byte[bit_idx];
                     if (tick_in_bit == 4'd0) begin
                        scl_out = 1'b0;
                        tick_in_bit = 4'd1;
                     end else if (tick_in_bit == 4'd1) begin
                        scl_out = 1'b1;
                        tick_in_bit = 4'd2;
                     end else begin
                        scl_out = 1'b0;
                        tick_in_bit = 4'd0;
                        if (bit_idx == 3'd0)
                           seq_phase = PH_ACK;
                        else
                           bit_idx = bit_idx - 3'd1;
                     end
                  end
                  PH_ACK: begin
                     if (tick_in_bit == 4'd0) begin
                        if (item.sda_in) begin
                           wait_next = {1'b0, ack_waits} + 21'd1;
                           if (wait_next > {1'b0, limit_cfg}) begin
                              scl_out = 1'b1;
                              sda_out = 1'b1;
                              timeout_seen = 1'b1;
                              seq_phase = PH_IDLE;
                              tick_in_bit = 4'd0;
                              done = 1'b1;
                           end else begin
                              ack_waits = wait_next[19:0];
                              scl_out = 1'b0;
                              sda_out = 1'b1;
                           end
                        end else begin
                           scl_out = 1'b0;
                           sda_out = 1'b1;
                           tick_in_bit = 4'd1;
                        end
                     end else if (tick_in_bit == 4'd1) begin
                        scl_out = 1'b1;
                        sda_out = 1'b1;
                        tick_in_bit = 4'd2;
                     end else begin
                        scl_out = 1'b0;
                        sda_out = 1'b1;
                        tick_in_bit = 4'd0;
                        if (next_byte < byte_total && int'(next_byte) < BUFFER_DEPTH) begin
                           tx_byte = frame_bytes[next_byte];
                           next_byte = next_byte + 5'd1;
                           bit_idx = 3'd7;
                           seq_phase = PH_BIT;
                        end else begin
                           seq_phase = PH_SP_SDA;
                        end
                     end
                  end
                  PH_SP_SDA: begin
                     scl_out = 1'b0;
                     sda_out = 1'b0;
                     seq_phase = PH_SP_SCL;
                  end
                  PH_SP_SCL: begin
                     scl_out = 1'b1;
                     sda_out = 1'b0;
                     tick_in_bit = 4'd0;
                     seq_phase = PH_SP_HOLD;
                  end
                  PH_SP_HOLD: begin
                     scl_out = 1'b1;
                     sda_out = 1'b1;
                     // A hold setting of zero behaves like a hold of one tick.
                     if (int'(tick_in_bit) + 1 >= int'(hold_cfg)) begin
                        seq_phase = PH_IDLE;
                        tick_in_bit = 4'd0;
                        done = 1'b1;
                     end else begin
                        tick_in_bit = tick_in_bit + 4'd1;
                     end
                  end
                  default: begin
                     seq_phase = PH_IDLE;
                     scl_out = 1'b1;
                     sda_out = 1'b1;
                  end
               endcase
            end
         end
         FUNC_LOAD: begin
            if (int'(item.buf_index) < BUFFER_DEPTH)
               frame_bytes[item.buf_index] = item.byte_value;
         end
         FUNC_START: begin
            if (seq_phase == PH_IDLE) begin
               tx_byte = item.address_byte;
               byte_total = (int'(item.byte_count) > BUFFER_DEPTH) ?
                            5'(BUFFER_DEPTH) : item.byte_count;
               next_byte = 5'd0;
               bit_idx = 3'd7;
               tick_in_bit = 4'd0;
               ack_waits = 20'd0;
               timeout_seen = 1'b0;
               seq_phase = PH_PRE;
            end
         end
         default: ;
      endcase
      lines.scl_level = scl_out;
      lines.sda_level = sda_out;
      lines.busy_res = (seq_phase != PH_IDLE);
      lines.frame_done = done;
      lines.timed_out = timeout_seen;
      return lines;
   endfunction

   function automatic void compare_field(string field, logic want, logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %b, got %b", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         seq_phase = PH_IDLE;
         bit_idx = 3'd7;
         tick_in_bit = 4'd0;
         next_byte = 5'd0;
         byte_total = 5'd0;
         tx_byte = 8'h00;
         ack_waits = 20'd0;
         scl_out = 1'b1;
         sda_out = 1'b1;
         timeout_seen = 1'b0;
         limit_cfg = ACK_LIMIT_RESET;
         hold_cfg = STOP_HOLD_RESET;
         line_queue.delete();
         fail_count = 0;
         expected_left = 0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_ACK_LIMIT)
               limit_cfg = csr_write_data[19:0];
            else
               hold_cfg = csr_write_data[3:0];
         end
         // Compare before predicting, so that a result cannot match a transaction
         // that is only being accepted at this same edge.
         if (rsp_valid && !rsp_stall) begin
            if (line_queue.size() == 0) begin
               $error("result transaction %b arrived with nothing expected", rsp_payload);
               fail_count++;
            end else begin
               want = line_queue.pop_front();
               compare_field("scl_level", want.scl_level, rsp_payload.scl_level);
               compare_field("sda_level", want.sda_level, rsp_payload.sda_level);
               compare_field("busy_res", want.busy_res, rsp_payload.busy_res);
               compare_field("frame_done", want.frame_done, rsp_payload.frame_done);
               compare_field("timed_out", want.timed_out, rsp_payload.timed_out);
            end
         end
         if (req_valid && !req_stall)
            line_queue.push_back(sequencer_step(req_payload));
         expected_left = line_queue.size();
      end
   end

endmodule

// ----- tb/i2c_master_write_sequencer_test.sv -----
`timescale 1ns / 1ps

// Top of the sequencer testbench. It only produces stimulus and gives the verdict; the
// checker beside the block watches both channels, predicts every result and compares.
module i2c_master_write_sequencer_test;
   import i2cmws_pkg::*;

   // The function code that the block must ignore entirely.
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam int ITEM_TARGET   = 1100;
   // Cycles without any accepted transaction before the run is declared hung. The
   // longest legal quiet stretch is the long receiver hold-off below.
   localparam int IDLE_LIMIT    = 3000;
   localparam int LONG_HOLD     = 300;
   // The block registers its answer to each accepted transaction, so this settling time
   // is plenty to catch any stray result after the last expected one.
   localparam int SETTLE_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic                  csr_index = CSR_ACK_LIMIT;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;

   int   fail_count;
   int   expected_left;
   int   quiet_cycles = 0;
   int   items_sent = 0;

   // Idle controls. The sender's flag is read only by the sending process; the
   // receiver's flags are written with nonblocking assignments so that the receiver
   // process sees them at the following falling edge, never in a race.
   logic tx_gaps = 1'b0;
   logic rx_gaps = 1'b0;
   logic long_hold_req = 1'b0;
   logic noise_on = 1'b0;

   always #1 clock = ~clock;

   i2c_master_write_sequencer u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

   i2cmws_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .fail_count     (fail_count),
      .expected_left  (expected_left)
   );

   // Watchdog: any accepted transaction or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver. It either holds off for one long stretch when asked, or stalls in short
   // random bursts while its gaps are enabled. Every burst ends with the stall released
   // before the next decision.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold_req <= 1'b0;
         end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every field is random, including the ones that the given function ignores, so
   // that all input bits toggle; callers override what matters.
   function automatic req_payload_type random_item(logic [1:0] func);
      req_payload_type item;
      item.func = func;
      item.sda_in = 1'($urandom_range(0, 1));
      item.buf_index = 4'($urandom_range(0, 15));
      item.byte_value = 8'($urandom_range(0, 255));
      item.byte_count = 5'($urandom_range(0, 31));
      item.address_byte = 8'($urandom_range(0, 255));
      return item;
   endfunction

   // Offers one transaction, starting at a falling edge, and returns at the falling
   // edge after it was accepted, or at the end of a random sender gap if one is taken.
   // Valid stays high into the next transaction unless such a gap is taken.
   task automatic offer(input req_payload_type item);
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (tx_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   // Stops offering and waits until every expected result has been received, which leaves
   // the block's output stage empty since each transaction yields exactly one result.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_write_data <= value;
      csr_write_en <= 1'b1;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // One frame: the start transaction followed by enough ticks to finish it in the
   // usual case. sda_in is high on the given share of ticks, which stretches the
   // acknowledge waits and, with a small limit, aborts the frame. Leftover ticks land
   // on an idle sequencer. Noise transactions (loads while busy, a start while busy,
   // the unused function code) are mixed in when enabled.
   task automatic run_frame(input logic [7:0] addr, input logic [4:0] count,
                            input int high_pct);
      req_payload_type item;
      int              data_bytes;
      int              ticks;
      item = random_item(FUNC_START);
      item.address_byte = addr;
      item.byte_count = count;
      offer(item);
      items_sent++;
      data_bytes = (int'(count) > 16) ? 16 : int'(count);
      ticks = 3 + (data_bytes + 1) * 29 + 2 + 16 + 8;
      for (int k = 0; k < ticks; k++) begin
         if (noise_on && $urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 2))
               0: item = random_item(FUNC_LOAD);
               1: item = random_item(FUNC_START);
               default: item = random_item(FUNC_NONE);
            endcase
            offer(item);
         end
         item = random_item(FUNC_TICK);
         item.sda_in = ($urandom_range(0, 99) < high_pct);
         offer(item);
         items_sent++;
      end
   endtask

   initial begin
      req_payload_type item;
      logic [19:0]     limit_pick;

      // Synchronous reset, held from the start and released at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Random idling on both sides during the directed part.
      tx_gaps = 1'b1;
      rx_gaps <= 1'b1;

      // Directed part. Fill the whole frame buffer first so that no frame can ever
      // send an entry that was never written; the values include both extremes.
      for (int i = 0; i < 16; i++) begin
         item = random_item(FUNC_LOAD);
         item.buf_index = 4'(i);
         case (i)
            0: item.byte_value = 8'h00;
            1: item.byte_value = 8'hFF;
            2: item.byte_value = 8'hA5;
            3: item.byte_value = 8'h5A;
            default: ;
         endcase
         offer(item);
         items_sent++;
      end

      // The unused function code and ticks on an idle sequencer change nothing.
      offer(random_item(FUNC_NONE));
      item = random_item(FUNC_TICK);
      item.sda_in = 1'b1;
      offer(item);
      item.sda_in = 1'b0;
      offer(item);

      // Default registers: a frame with no data bytes goes straight from the address
      // acknowledge to the stop, and an oversized count saturates to the buffer depth.
      run_frame(8'h00, 5'd0, 0);

      // During the long frame the receiver stops for a long stretch while the
      // sender keeps offering, so the block fills up and stalls its input.
      long_hold_req <= 1'b1;
      run_frame(8'hFF, 5'd31, 0);

      // A limit of zero aborts on the first high acknowledge sample; a hold of zero
      // acts as a single hold tick.
      drain();
      write_csr(CSR_ACK_LIMIT, '0);
      write_csr(CSR_STOP_HOLD, '0);
      run_frame(8'h5A, 5'd1, 100);
      run_frame(8'hA5, 5'd2, 0);

      // Largest limit and longest hold.
      drain();
      write_csr(CSR_ACK_LIMIT, 20'hFFFFF);
      write_csr(CSR_STOP_HOLD, 20'd15);
      run_frame(8'h3C, 5'd3, 50);

      // Smallest nonzero settings; the frame aborts on its second high sample.
      drain();
      write_csr(CSR_ACK_LIMIT, 20'd1);
      write_csr(CSR_STOP_HOLD, 20'd1);
      run_frame(8'hC3, 5'd2, 100);

      // Random part. Each phase drains, picks new register values and runs a frame
      // with random content. Most counts are small to keep frames short.
      noise_on = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         drain();
         case ($urandom_range(0, 5))
            0: limit_pick = 20'd0;
            1: limit_pick = 20'd1;
            2: limit_pick = 20'($urandom_range(2, 6));
            3: limit_pick = 20'($urandom_range(7, 60));
            4: limit_pick = 20'hFFFFF;
            default: limit_pick = ACK_LIMIT_RESET;
         endcase
         write_csr(CSR_ACK_LIMIT, limit_pick);
         write_csr(CSR_STOP_HOLD, 20'($urandom_range(0, 15)));

         // Idling is random per phase, and the last part of the run has none.
         if (items_sent > ITEM_TARGET * 4 / 5) begin
            tx_gaps = 1'b0;
            rx_gaps <= 1'b0;
         end else begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps <= ($urandom_range(0, 3) != 0);
         end

         run_frame(8'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) == 0) ? 5'($urandom_range(4, 31))
                                               : 5'($urandom_range(0, 3)),
                   $urandom_range(0, 40));
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_left == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- i2c_master_write_sequencer.f -----
rtl/i2cmws_pkg.sv
rtl/i2cmws_buf.sv
rtl/i2cmws_seq.sv
rtl/i2cmws_skid.sv
rtl/i2c_master_write_sequencer.sv
tb/i2cmws_checker.sv
tb/i2c_master_write_sequencer_test.sv
